### design/ssr_pkg.sv
package ssr_pkg;

  // Command codes; the unused code behaves as a peek.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam int unsigned NUM_ROUNDS  = 64;
  localparam int unsigned ROUND_W     = $clog2(NUM_ROUNDS);
  localparam int unsigned SCHED_DEPTH = 16;

  // Padding for a 16-byte message: marker word after the data, length 128 bits.
  localparam logic [31:0] PAD_MARKER = 32'h8000_0000;
  localparam logic [31:0] MSG_BITS   = 32'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } ssr_state_e;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

### design/sha256_seed_ratchet_core.sv
// Channel  Dir  Width  Contents (tdata, lowest bit first)
// s_axis   in   264    cmd[1:0], seed_hi[65:2], seed_lo[129:66],
//                      start_time[193:130], step_size[257:194], zero fill
// m_axis   out  192    id_hi[63:0], id_lo[127:64], time_now[191:128]
//
// For each request the core accepts it and loads the hash state, runs 64 rounds
// of the shared SHA-256 round unit (one round per cycle), and then folds in the
// initial hash and commits seed and timestamp. Input is taken only while idle.
// The result register lets the next request start while a result is pending;
// the finish cycle holds until that result has been taken.
// Reset (rst_ni low, asynchronous) clears the seed, the timestamp and control.
module sha256_seed_ratchet_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [263:0] s_axis_tdata_i,   // cmd, seed_hi, seed_lo, start_time, step_size
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [191:0] m_axis_tdata_o    // id_hi, id_lo, time_now
);
  import ssr_pkg::*;

  ssr_state_e state_q, state_d;

  logic [ROUND_W-1:0] rnd_q, rnd_d;
  logic               m_valid_q, m_valid_d;
  logic [63:0]        seed_hi_q, seed_hi_d;
  logic [63:0]        seed_lo_q, seed_lo_d;
  logic [63:0]        time_q, time_d;

  logic [1:0]         cmd_q;
  logic [63:0]        step_q;
  logic [31:0]        a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [31:0]        w_q [SCHED_DEPTH];
  logic [63:0]        id_hi_q, id_lo_q, time_now_q;

  logic               in_ready;
  logic               do_round;
  logic               do_finish;
  logic               accept;

  logic [1:0]         in_cmd;
  logic [63:0]        in_seed_hi, in_seed_lo, in_start, in_step;
  logic [63:0]        src_hi, src_lo;

  logic [31:0]        t1, t2, w_next;
  logic [31:0]        dig [8];
  logic [63:0]        time_next;

  assign in_cmd     = s_axis_tdata_i[1:0];
  assign in_seed_hi = s_axis_tdata_i[65:2];
  assign in_seed_lo = s_axis_tdata_i[129:66];
  assign in_start   = s_axis_tdata_i[193:130];
  assign in_step    = s_axis_tdata_i[257:194];

  assign accept = s_axis_tvalid_i & in_ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_q == ROUND_W'(NUM_ROUNDS - 1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    do_round  = 1'b0;
    do_finish = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready  = 1'b1;
      ST_ROUND:  do_round  = 1'b1;
      ST_FINISH: do_finish = !m_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  // A load hashes the incoming seed; other commands hash the stored one.
  assign src_hi = (in_cmd == CMD_LOAD) ? in_seed_hi : seed_hi_q;
  assign src_lo = (in_cmd == CMD_LOAD) ? in_seed_lo : seed_lo_q;

  // Shared round unit.
  assign t1 = h_q + big_sigma1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[rnd_q] + w_q[0];
  assign t2 = big_sigma0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
  assign w_next = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);

  assign dig[0] = INIT_H[0] + a_q;
  assign dig[1] = INIT_H[1] + b_q;
  assign dig[2] = INIT_H[2] + c_q;
  assign dig[3] = INIT_H[3] + d_q;
  assign dig[4] = INIT_H[4] + e_q;
  assign dig[5] = INIT_H[5] + f_q;
  assign dig[6] = INIT_H[6] + g_q;
  assign dig[7] = INIT_H[7] + h_q;

  assign time_next = (cmd_q == CMD_STEP) ? time_q + step_q : time_q;

  always_comb begin
    rnd_d     = rnd_q;
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    seed_hi_d = seed_hi_q;
    seed_lo_d = seed_lo_q;
    time_d    = time_q;
    if (accept) begin
      rnd_d = '0;
      if (in_cmd == CMD_LOAD) begin
        seed_hi_d = in_seed_hi;
        seed_lo_d = in_seed_lo;
        time_d    = in_start;
      end
    end
    if (do_round) rnd_d = rnd_q + ROUND_W'(1);
    if (do_finish) begin
      m_valid_d = 1'b1;
      time_d    = time_next;
      if (cmd_q == CMD_STEP) begin
        seed_hi_d = {dig[0], dig[1]};
        seed_lo_d = {dig[2], dig[3]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rnd_q     <= '0;
      m_valid_q <= 1'b0;
      seed_hi_q <= '0;
      seed_lo_q <= '0;
      time_q    <= '0;
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      m_valid_q <= m_valid_d;
      seed_hi_q <= seed_hi_d;
      seed_lo_q <= seed_lo_d;
      time_q    <= time_d;
    end
  end

  // Hash working state, message schedule and result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd;
      step_q <= in_step;
      a_q <= INIT_H[0];
      b_q <= INIT_H[1];
      c_q <= INIT_H[2];
      d_q <= INIT_H[3];
      e_q <= INIT_H[4];
      f_q <= INIT_H[5];
      g_q <= INIT_H[6];
      h_q <= INIT_H[7];
      w_q[0] <= src_hi[63:32];
      w_q[1] <= src_hi[31:0];
      w_q[2] <= src_lo[63:32];
      w_q[3] <= src_lo[31:0];
      w_q[4] <= PAD_MARKER;
      for (int i = 5; i < SCHED_DEPTH - 1; i++) begin
        w_q[i] <= '0;
      end
      w_q[SCHED_DEPTH-1] <= MSG_BITS;
    end else if (do_round) begin
      a_q <= t1 + t2;
      b_q <= a_q;
      c_q <= b_q;
      d_q <= c_q;
      e_q <= d_q + t1;
      f_q <= e_q;
      g_q <= f_q;
      h_q <= g_q;
      for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[SCHED_DEPTH-1] <= w_next;
    end
    if (do_finish) begin
      id_hi_q    <= {dig[4], dig[5]};
      id_lo_q    <= {dig[6], dig[7]};
      time_now_q <= time_next;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {time_now_q, id_lo_q, id_hi_q};

endmodule

### verif/testbench.sv
module testbench;
  import ssr_pkg::*;

  // The spare command code; the block treats it as a peek.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned RANDOM_CMDS = 1600;
  localparam int unsigned DRAIN_EVERY = 400;
  localparam int unsigned MAX_WAIT = 12;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [1:0]         cmd;
    logic [63:0]        seed_hi;
    logic [63:0]        seed_lo;
    logic signed [63:0] start_time;
    logic signed [63:0] step_size;
    bit                 drain_first;
  } ratchet_cmd_t;

  typedef struct {
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [63:0] time_now;
  } ratchet_id_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;

  ratchet_cmd_t pending_cmds [$];
  ratchet_id_t  expected_ids [$];

  // Predicted ratchet state.
  logic [127:0] chain_seed = '0;
  logic [63:0]  chain_time = '0;

  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_load = 0, n_step = 0, n_peek = 0, n_spare = 0;

  int unsigned send_gap = 0;
  int unsigned take_stall = 0;
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;
  bit          req_taken;
  bit          offer;
  ratchet_id_t got_id;
  ratchet_id_t want_id;

  always #1 clk = ~clk;

  sha256_seed_ratchet_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Single-block SHA-256 of the 16 seed bytes, digest word 0 in the top bits.
  function automatic logic [255:0] seed_digest(logic [127:0] seed);
    logic [31:0]  w [64];
    logic [31:0]  v [8];
    logic [31:0]  t1, t2;
    logic [255:0] dig;
    for (int i = 0; i < 64; i++) w[i] = '0;
    w[0] = seed[127:96];
    w[1] = seed[95:64];
    w[2] = seed[63:32];
    w[3] = seed[31:0];
    w[4] = 32'h8000_0000;
    w[15] = 32'd128;
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = HASH_IV[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = HASH_IV[i] + v[i];
    return dig;
  endfunction

  // Apply one accepted request to the predicted state and queue its identifier.
  function automatic void advance_ratchet(ratchet_cmd_t c);
    logic [255:0] dig;
    ratchet_id_t  r;
    if (c.cmd == CMD_LOAD) begin
      chain_seed = {c.seed_hi, c.seed_lo};
      chain_time = c.start_time;
    end
    dig = seed_digest(chain_seed);
    if (c.cmd == CMD_STEP) begin
      chain_seed = dig[255:128];
      chain_time = chain_time + c.step_size;
    end
    r.id_hi = dig[127:64];
    r.id_lo = dig[63:0];
    r.time_now = chain_time;
    expected_ids.push_back(r);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'd1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic void queue_cmd(logic [1:0] cmd, logic [63:0] hi, logic [63:0] lo,
                                    logic [63:0] start, logic [63:0] step, bit drain);
    ratchet_cmd_t c;
    c.cmd = cmd;
    c.seed_hi = hi;
    c.seed_lo = lo;
    c.start_time = start;
    c.step_size = step;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("result %0d %s: expected %016h, got %016h", results_seen, what, want, got);
  endfunction

  // Request driver: hold each request until taken, then wait a drawn gap.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      requests_sent <= 0;
    end else begin
      req_taken = s_tvalid && s_tready;
      if (req_taken) begin
        advance_ratchet(pending_cmds[0]);
        case (pending_cmds[0].cmd)
          CMD_LOAD: n_load++;
          CMD_STEP: n_step++;
          CMD_PEEK: n_peek++;
          default: n_spare++;
        endcase
        void'(pending_cmds.pop_front());
        requests_sent <= requests_sent + 1;
        if ($urandom_range(0, 59) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      offer = 1'b0;
      if (s_tvalid && !req_taken) begin
        offer = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() > 0) begin
        // A drain request waits until every earlier identifier has come back.
        if (!pending_cmds[0].drain_first || requests_sent + req_taken == results_seen)
          offer = 1'b1;
      end
      s_tvalid <= offer;
      if (offer)
        s_tdata <= {6'd0, pending_cmds[0].step_size, pending_cmds[0].start_time,
                    pending_cmds[0].seed_lo, pending_cmds[0].seed_hi, pending_cmds[0].cmd};
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
      results_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_id.id_hi = m_tdata[63:0];
        got_id.id_lo = m_tdata[127:64];
        got_id.time_now = m_tdata[191:128];
        results_seen <= results_seen + 1;
        if (expected_ids.size() == 0) begin
          note_mismatch("unexpected, id_hi", '0, got_id.id_hi);
        end else begin
          want_id = expected_ids.pop_front();
          if (got_id.id_hi !== want_id.id_hi) note_mismatch("id_hi", want_id.id_hi, got_id.id_hi);
          if (got_id.id_lo !== want_id.id_lo) note_mismatch("id_lo", want_id.id_lo, got_id.id_lo);
          if (got_id.time_now !== want_id.time_now)
            note_mismatch("time_now", want_id.time_now, got_id.time_now);
        end
        if ($urandom_range(0, 59) == 0) take_steady = !take_steady;
        take_stall = take_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      m_tready <= (take_stall == 0);
      if (take_stall > 0) take_stall--;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("sha256_seed_ratchet_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed: reset seed, timestamp wrap both ways, extreme seeds, spare code.
    queue_cmd(CMD_PEEK, '1, '1, '1, '1, 1'b0);
    queue_cmd(CMD_SPARE, '1, '0, '1, '0, 1'b0);
    queue_cmd(CMD_STEP, '1, '1, '1, 64'd5, 1'b0);
    queue_cmd(CMD_LOAD, '0, '0, '0, '1, 1'b0);
    queue_cmd(CMD_PEEK, '0, '0, '0, '0, 1'b0);
    queue_cmd(CMD_LOAD, '1, '1, 64'h7fff_ffff_ffff_ffff, '0, 1'b0);
    queue_cmd(CMD_STEP, '0, '0, '0, 64'd1, 1'b0);
    queue_cmd(CMD_STEP, '0, '0, '0, 64'h8000_0000_0000_0000, 1'b0);
    queue_cmd(CMD_LOAD, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
              64'h8000_0000_0000_0000, '0, 1'b0);
    queue_cmd(CMD_STEP, '0, '0, '0, '1, 1'b0);
    queue_cmd(CMD_STEP, '0, '0, '0, 64'h7fff_ffff_ffff_ffff, 1'b0);
    queue_cmd(CMD_SPARE, '0, '0, '0, '0, 1'b0);
    queue_cmd(CMD_STEP, '1, '1, '1, '0, 1'b0);
    queue_cmd(CMD_LOAD, 64'h8000_0000_0000_0000, 64'd1, '1, '1, 1'b0);
    queue_cmd(CMD_STEP, '0, '0, '0, 64'h8000_0000_0000_0000, 1'b0);
    queue_cmd(CMD_PEEK, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, '1, '1, 1'b0);
    for (int i = 0; i < 3; i++)
      queue_cmd(CMD_STEP, rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
    queue_cmd(CMD_LOAD, rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
    queue_cmd(CMD_STEP, rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);

    // Random: half steps, with loads, peeks and the spare code mixed in.
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      int unsigned pick;
      logic [1:0]  cmd;
      pick = $urandom_range(0, 19);
      if (pick < 3) cmd = CMD_LOAD;
      else if (pick < 13) cmd = CMD_STEP;
      else if (pick < 18) cmd = CMD_PEEK;
      else cmd = CMD_SPARE;
      queue_cmd(cmd, rand_word(), rand_word(), rand_word(), rand_word(),
                (i % DRAIN_EVERY) == DRAIN_EVERY - 1);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || s_tvalid) @(negedge clk);
    while (results_seen != requests_sent) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_ids.size() != 0) begin
      mismatches++;
      $display("%0d identifiers never arrived", expected_ids.size());
    end

    $display("checked %0d results: %0d loads, %0d steps, %0d peeks, %0d spare-code peeks",
             results_seen, n_load, n_step, n_peek, n_spare);
    $display("timestamp wrap, extreme seeds, drain pauses and random stalls exercised; %0d errors",
             mismatches);
    if (mismatches == 0) begin
      $display("sha256_seed_ratchet_core: match");
    end else begin
      $display("sha256_seed_ratchet_core: mismatch");
    end
    $finish;
  end

endmodule

### sha256_seed_ratchet_core.f
design/ssr_pkg.sv
design/sha256_seed_ratchet_core.sv
verif/testbench.sv
